/* hw/rtl/asmtok_pkg.sv */
// Shared types and constants for the assembly source tokenizer.
// Holds the input and token payload structs, the result bundle and queue status.
// No dependencies.
package asmtok_pkg;

	// Token kinds
	localparam logic [2:0] KIND_NEWLINE = 3'd0;
	localparam logic [2:0] KIND_STRING  = 3'd1;
	localparam logic [2:0] KIND_NUMBER  = 3'd2;
	localparam logic [2:0] KIND_IDENT   = 3'd3;
	localparam logic [2:0] KIND_COLON   = 3'd4;
	localparam logic [2:0] KIND_HEAD    = 3'd5;
	localparam logic [2:0] KIND_TAIL    = 3'd6;

	// Characters with a meaning to the scanner
	localparam logic [7:0] CHAR_SEMI    = 8'h3B;
	localparam logic [7:0] CHAR_QUOTE   = 8'h22;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_USCORE  = 8'h5F;
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Results one input item may cause, and bundle sizing
	localparam int MAX_RES    = 4;
	localparam int RES_IDX_W  = $clog2(MAX_RES);
	localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] token_char;
		logic       has_char;
		logic       token_end;
	} token_item_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]        count;
		token_item_t [MAX_RES-1:0]   res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_status_t;

endpackage

/* hw/rtl/asmtok_front.sv */
// Front end of the tokenizer: accepts source bytes and classifies them.
// Runs the scan mode, builds the bundle of token results for each byte.
// Depends on asmtok_pkg.
module asmtok_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  asmtok_pkg::byte_item_t     byte_data,
	input  asmtok_pkg::queue_status_t  q_status,
	output logic                       push,
	output asmtok_pkg::bundle_t        push_data
);
	import asmtok_pkg::*;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_STRING  = 3'd2;
	localparam logic [2:0] MODE_NUMBER  = 3'd3;
	localparam logic [2:0] MODE_IDENT   = 3'd4;

	logic [2:0] mode_q, mode_d;
	logic       neg_q, neg_d;
	logic       head_q, head_d;
	logic       do_idle;
	logic       accept;
	logic [7:0] c;
	bundle_t    body;

	function automatic logic is_digit(logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_letter(logic [7:0] ch);
		return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
	endfunction

	function automatic token_item_t mk(logic [2:0] kind, logic [7:0] ch, logic has,
			logic fin);
		token_item_t t;
		t.token_kind = kind;
		t.token_char = has ? ch : 8'h00;
		t.has_char   = has;
		t.token_end  = fin;
		return t;
	endfunction

	function automatic bundle_t append(bundle_t b, token_item_t r);
		b.res[b.count[RES_IDX_W-1:0]] = r;
		b.count = b.count + RES_CNT_W'(1);
		return b;
	endfunction

	assign c = byte_data.char_byte;

	// Classify the byte against the current mode
	always_comb begin
		body    = '0;
		mode_d  = mode_q;
		neg_d   = neg_q;
		do_idle = 1'b0;
		if (byte_data.cmd) begin
			case (mode_q)
				MODE_STRING: body = append(body, mk(KIND_STRING, 8'h00, 1'b0, 1'b1));
				MODE_NUMBER: body = append(body, mk(KIND_NUMBER, 8'h00, 1'b0, 1'b1));
				MODE_IDENT:  body = append(body, mk(KIND_IDENT, 8'h00, 1'b0, 1'b1));
				default: ;
			endcase
			body   = append(body, mk(KIND_TAIL, 8'h00, 1'b0, 1'b1));
			mode_d = MODE_IDLE;
			neg_d  = 1'b0;
		end else begin
			case (mode_q)
				MODE_COMMENT: begin
					if (c == CHAR_NEWLINE) mode_d = MODE_IDLE;
				end
				MODE_STRING: begin
					if (c == CHAR_QUOTE) begin
						body   = append(body, mk(KIND_STRING, 8'h00, 1'b0, 1'b1));
						mode_d = MODE_IDLE;
					end else begin
						body = append(body, mk(KIND_STRING, c, 1'b1, 1'b0));
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c) || c == CHAR_DOT) begin
						body = append(body, mk(KIND_NUMBER, c, 1'b1, 1'b0));
					end else begin
						body    = append(body, mk(KIND_NUMBER, 8'h00, 1'b0, 1'b1));
						mode_d  = MODE_IDLE;
						do_idle = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_letter(c) || is_digit(c) || c == CHAR_USCORE) begin
						body = append(body, mk(KIND_IDENT, c, 1'b1, 1'b0));
					end else begin
						body    = append(body, mk(KIND_IDENT, 8'h00, 1'b0, 1'b1));
						mode_d  = MODE_IDLE;
						do_idle = 1'b1;
					end
				end
				default: begin
					mode_d  = MODE_IDLE;
					do_idle = 1'b1;
				end
			endcase
			// Handle the byte as in idle
			if (do_idle) begin
				if (c == CHAR_NEWLINE) begin
					body = append(body, mk(KIND_NEWLINE, 8'h00, 1'b0, 1'b1));
				end else if (c == CHAR_SEMI) begin
					mode_d = MODE_COMMENT;
				end else if (c == CHAR_QUOTE) begin
					mode_d = MODE_STRING;
				end else if (is_digit(c)) begin
					if (neg_q) begin
						body  = append(body, mk(KIND_NUMBER, CHAR_MINUS, 1'b1, 1'b0));
						neg_d = 1'b0;
					end
					body   = append(body, mk(KIND_NUMBER, c, 1'b1, 1'b0));
					mode_d = MODE_NUMBER;
				end else if (is_letter(c) || c == CHAR_USCORE) begin
					body   = append(body, mk(KIND_IDENT, c, 1'b1, 1'b0));
					mode_d = MODE_IDENT;
				end else if (c == CHAR_COLON) begin
					body = append(body, mk(KIND_COLON, c, 1'b1, 1'b1));
				end else if (c == CHAR_MINUS) begin
					neg_d = 1'b1;
				end
			end
		end
	end

	// Put the head token in front of the first result of a stream
	always_comb begin
		push_data = body;
		if (!head_q && body.count != '0) begin
			push_data.res[0] = mk(KIND_HEAD, 8'h00, 1'b0, 1'b1);
			for (int i = 1; i < MAX_RES; i++) begin
				push_data.res[i] = body.res[i-1];
			end
			push_data.count = body.count + RES_CNT_W'(1);
		end
		head_d = byte_data.cmd ? 1'b0 : (head_q | (body.count != '0));
	end

	assign byte_stall = q_status.full;
	assign accept     = byte_valid && !byte_stall;
	assign push       = accept && (push_data.count != '0);

	// Advance scan state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			neg_q  <= 1'b0;
			head_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			neg_q  <= neg_d;
			head_q <= head_d;
		end
	end

endmodule

/* hw/rtl/asmtok_queue.sv */
// Bundle queue between the tokenizer front and back ends.
// Small register FIFO of result bundles with full and non-empty status.
// Depends on asmtok_pkg.
module asmtok_queue #(
	parameter int DEPTH = asmtok_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  asmtok_pkg::bundle_t        push_data,
	input  logic                       pop,
	output asmtok_pkg::bundle_t        head_data,
	output asmtok_pkg::queue_status_t  q_status
);
	import asmtok_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign q_status.full     = (cnt_q == CNT_W'(DEPTH));
	assign q_status.nonempty = (cnt_q != '0);
	assign head_data         = entries_q[rd_ptr_q];

	// Store incoming bundles
	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

/* hw/rtl/asmtok_back.sv */
// Back end of the tokenizer: plays out each bundle one token result at a time.
// Drives the registered token output channel.
// Depends on asmtok_pkg.
module asmtok_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  asmtok_pkg::queue_status_t  q_status,
	input  asmtok_pkg::bundle_t        head_data,
	output logic                       pop,
	output logic                       token_valid,
	input  logic                       token_stall,
	output asmtok_pkg::token_item_t    token_data
);
	import asmtok_pkg::*;

	logic [RES_IDX_W-1:0] idx_q;
	logic                 valid_q;
	token_item_t          data_q;
	logic                 load;
	logic                 last;

	assign load = q_status.nonempty && (!valid_q || !token_stall);
	assign last = ({1'b0, idx_q} == RES_CNT_W'(head_data.count - RES_CNT_W'(1)));
	assign pop  = load && last;

	// Step through the bundle at the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last ? '0 : idx_q + RES_IDX_W'(1);
		end else if (!token_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the output payload until transfer
	always_ff @(posedge clk) begin
		if (load) data_q <= head_data.res[idx_q];
	end

	assign token_valid = valid_q;
	assign token_data  = data_q;

endmodule

/* hw/rtl/assembly_source_tokenizer_core.sv */
// Assembly source tokenizer, top level.
// Throughput: one source byte per cycle while each byte yields at most one token result
// and token_stall is low; the output gives one result per cycle unless stalled, so the
// results of a byte leave in turn, the first via a queue entry and the output register.
// A four-bundle queue between front and back end sets how far input runs ahead of output.
// Reset (arst_n low) returns to idle mode with no minus pending and no head sent.
module assembly_source_tokenizer_core #(
	parameter int QDEPTH = asmtok_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  asmtok_pkg::byte_item_t   byte_data,
	output logic                     token_valid,
	input  logic                     token_stall,
	output asmtok_pkg::token_item_t  token_data
);
	import asmtok_pkg::*;

	queue_status_t q_status;
	bundle_t       push_data;
	bundle_t       head_data;
	logic          push;
	logic          pop;

	asmtok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	asmtok_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.q_status  (q_status)
	);

	asmtok_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head_data   (head_data),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

	// Never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("bundle pushed into full queue");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.nonempty)
		else $error("bundle popped from empty queue");

	// A result without a character carries a zero character
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !token_data.has_char) |-> (token_data.token_char == 8'h00))
		else $error("character set on result without character");

	// Head and tail tokens are single closing results
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && (token_data.token_kind == KIND_HEAD
			|| token_data.token_kind == KIND_TAIL))
		|-> (token_data.token_end && !token_data.has_char))
		else $error("malformed head or tail token");

endmodule
